// File: hw/rtl/fdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdu_pkg;

  // Request codes on req_type
  typedef enum logic {
    REQ_SEND = 1'b0,
    REQ_TICK = 1'b1
  } fdu_req_t;

  // Result kinds on result_kind
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_INC  = 2'd0,
    REG_SPACE_INC = 2'd1
  } fdu_reg_t;

  localparam logic [31:0] MARK_INC_RST  = 32'd214748364;
  localparam logic [31:0] SPACE_INC_RST = 32'd393705335;

  // 8O1 frame: start, eight data bits, parity, stop
  localparam int FRAME_LEN = 11;
  localparam int BIT_IDX_W = 4;

  // Sine memory
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW    = 8;
  localparam int SAMPLE_W  = 12;
  localparam logic [SAMPLE_W-1:0] MID_CODE = 12'd2048;

  // Per-result control bits carried down the lookup pipeline
  typedef struct packed {
    logic kind;
    logic acc;
    logic busy;
    logic last;
  } fdu_meta_t;

  typedef struct packed {
    fdu_meta_t   meta;
    logic [31:0] phase;
  } fdu_token_t;

  // Quarter wave of 1900*sin, 65 points including both ends
  localparam logic [10:0] QUARTER_WAVE [65] = '{
    11'd0,    11'd46,   11'd93,   11'd139,  11'd186,  11'd232,  11'd278,  11'd324,
    11'd370,  11'd416,  11'd461,  11'd506,  11'd551,  11'd595,  11'd640,  11'd683,
    11'd727,  11'd769,  11'd812,  11'd854,  11'd895,  11'd936,  11'd976,  11'd1016,
    11'd1055, 11'd1094, 11'd1131, 11'd1168, 11'd1205, 11'd1241, 11'd1275, 11'd1310,
    11'd1343, 11'd1376, 11'd1407, 11'd1438, 11'd1468, 11'd1497, 11'd1526, 11'd1553,
    11'd1579, 11'd1605, 11'd1629, 11'd1653, 11'd1675, 11'd1697, 11'd1717, 11'd1736,
    11'd1755, 11'd1772, 11'd1788, 11'd1804, 11'd1818, 11'd1831, 11'd1843, 11'd1853,
    11'd1863, 11'd1872, 11'd1879, 11'd1885, 11'd1890, 11'd1894, 11'd1897, 11'd1899,
    11'd1900
  };

  // Full-wave sine code built from the quarter wave by quadrant
  function automatic logic [SAMPLE_W-1:0] sine_code(input logic [ROM_AW-1:0] addr);
    logic [6:0]  fwd;
    logic [6:0]  rev;
    logic [10:0] amp;
    fwd = {1'b0, addr[5:0]};
    rev = 7'd64 - fwd;
    amp = addr[6] ? QUARTER_WAVE[rev] : QUARTER_WAVE[fwd];
    if (addr[7]) begin
      sine_code = MID_CODE - {1'b0, amp};
    end else begin
      sine_code = MID_CODE + {1'b0, amp};
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fdu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fdu_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fdu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fdu_ctrl #(
  parameter int SAMPLES_PER_BIT = 20
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                req_type,
  input  wire logic [7:0]          byte_in,
  input  wire logic [31:0]         mark_inc,
  input  wire logic [31:0]         space_inc,
  input  wire logic                fill_done,
  input  wire logic                adv,
  output      logic                tok_valid,
  output      fdu_pkg::fdu_token_t tok
);

  localparam int CW = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 1;

  logic [31:0]                     phase;
  logic [fdu_pkg::FRAME_LEN-1:0]   frame_bits;
  logic [fdu_pkg::BIT_IDX_W-1:0]   bit_index;
  logic                            busy;

  // Current job: one ack or a run of samples
  logic          job_active;
  logic          job_kind;
  logic          job_acc;
  logic          job_busy;
  logic [31:0]   job_inc;
  logic [CW-1:0] job_cnt;

  logic [fdu_pkg::FRAME_LEN-1:0] frame_next;
  logic [fdu_pkg::BIT_IDX_W-1:0] bit_index_next;
  logic                          busy_next;
  logic                          bit_val;
  logic                          acc;
  logic                          accept;
  logic                          fire;
  logic                          job_last;
  logic                          done;

  assign job_last = (job_kind == fdu_pkg::KIND_ACK) || (job_cnt == CW'(SAMPLES_PER_BIT - 1));
  assign fire     = job_active && adv;
  assign done     = fire && job_last;
  assign in_ready = fill_done && (!job_active || done);
  assign accept   = in_valid && in_ready;

  // Framing and bit taking
  always_comb begin
    frame_next     = frame_bits;
    bit_index_next = bit_index;
    busy_next      = busy;
    bit_val        = 1'b1;
    acc            = 1'b0;
    if (accept) begin
      if (req_type == fdu_pkg::REQ_SEND) begin
        if (!busy) begin
          frame_next     = {1'b1, ~(^byte_in), byte_in, 1'b0};
          bit_index_next = '0;
          busy_next      = 1'b1;
          acc            = 1'b1;
        end
      end else if (busy) begin
        if (bit_index >= fdu_pkg::BIT_IDX_W'(fdu_pkg::FRAME_LEN)) begin
          bit_index_next = '0;
          busy_next      = 1'b0;
        end else begin
          bit_val = frame_bits[bit_index];
          if (bit_index == fdu_pkg::BIT_IDX_W'(fdu_pkg::FRAME_LEN - 1)) begin
            bit_index_next = '0;
            busy_next      = 1'b0;
          end else begin
            bit_index_next = bit_index + 1'b1;
          end
        end
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    frame_bits <= frame_next;
    if (rst) begin
      bit_index <= '0;
      busy      <= 1'b0;
    end else begin
      bit_index <= bit_index_next;
      busy      <= busy_next;
    end
  end

  // Job registers and phase accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      job_cnt    <= '0;
      phase      <= '0;
    end else begin
      if (fire) begin
        job_cnt <= job_cnt + 1'b1;
        if (job_kind == fdu_pkg::KIND_SAMPLE) begin
          phase <= phase + job_inc;
        end
      end
      if (accept) begin
        job_active <= 1'b1;
        job_cnt    <= '0;
      end else if (done) begin
        job_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_kind <= (req_type == fdu_pkg::REQ_TICK) ? fdu_pkg::KIND_SAMPLE : fdu_pkg::KIND_ACK;
      job_acc  <= acc;
      job_busy <= busy_next;
      job_inc  <= bit_val ? mark_inc : space_inc;
    end
  end

  assign tok_valid      = job_active;
  assign tok.meta.kind  = job_kind;
  assign tok.meta.acc   = job_acc;
  assign tok.meta.busy  = job_busy;
  assign tok.meta.last  = job_last;
  assign tok.phase      = phase;

endmodule

`default_nettype wire

// File: hw/rtl/fdu_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

module fdu_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tok_valid,
  input  wire fdu_pkg::fdu_token_t           tok,
  output      logic                          adv,
  output      logic                          fill_done,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      fdu_pkg::fdu_meta_t            out_meta,
  output      logic [fdu_pkg::SAMPLE_W-1:0]  out_sample
);

  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = 32 + TW;
  // Reciprocal for idx*256/TABLE_DEPTH: ceil(2^33 / TABLE_DEPTH), used as >> 25
  localparam longint unsigned RECIP = ((64'd1 << 33) + 64'(TABLE_DEPTH) - 64'd1)
                                      / 64'(TABLE_DEPTH);
  localparam int RW = $clog2(RECIP + 1);
  localparam int QW = IW + RW;

  logic [fdu_pkg::ROM_AW:0] fill_cnt;
  logic                     fill_we;

  logic               v1;
  fdu_pkg::fdu_meta_t m1;
  logic [IW-1:0]      idx1;
  logic               v2;
  fdu_pkg::fdu_meta_t m2;
  logic [fdu_pkg::ROM_AW-1:0] addr2;
  logic               v3;
  fdu_pkg::fdu_meta_t m3;
  logic [fdu_pkg::SAMPLE_W-1:0] rdata;

  logic [PW-1:0] prod1;
  logic [QW-1:0] prod2;

  // Sine memory load after reset, one entry per cycle
  assign fill_done = fill_cnt[fdu_pkg::ROM_AW];
  assign fill_we   = !fill_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (fill_we) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // Whole pipeline moves while the output slot is free or being taken
  assign adv = !v3 || out_ready;

  assign prod1 = PW'(tok.phase) * PW'(TABLE_DEPTH);
  assign prod2 = QW'(idx1) * QW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= tok_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: scale phase to the table, stage 2: map onto the sine memory
  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= tok.meta;
      idx1  <= prod1[32 +: IW];
      m2    <= m1;
      addr2 <= prod2[25 +: fdu_pkg::ROM_AW];
      m3    <= m2;
    end
  end

  // Stage 3: sine memory read
  fdu_ram #(
    .WIDTH (fdu_pkg::SAMPLE_W),
    .DEPTH (fdu_pkg::ROM_DEPTH)
  ) u_sine (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_cnt[fdu_pkg::ROM_AW-1:0]),
    .wdata (fdu_pkg::sine_code(fill_cnt[fdu_pkg::ROM_AW-1:0])),
    .re    (adv),
    .raddr (addr2),
    .rdata (rdata)
  );

  assign out_valid  = v3;
  assign out_meta   = m3;
  assign out_sample = (m3.kind == fdu_pkg::KIND_SAMPLE) ? rdata : '0;

endmodule

`default_nettype wire

// File: hw/rtl/fsk_dds_uart_modulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Continuous-phase FSK transmitter with 8O1 byte framing.
// Input channel (in_valid/in_ready): req_type 0 is a send request for byte_in,
// req_type 1 is a bit tick. A send yields one acknowledgement transaction; a tick
// yields SAMPLES_PER_BIT sample transactions, the last one flagged by last.
// Output channel (out_valid/out_ready) carries one result per cycle at most.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 mark increment,
// index 1 space increment; other indexes are ignored. Write only while idle.
// The first result passes the job registers and the lookup stages before it is presented.
// Throughput: one result per cycle unless the output stalls, so a send every
// cycle; the next item is taken in the cycle the current job issues its last
// result into the lookup pipeline.
// Reset: phase and frame state clear, then the sine memory is loaded, one entry a
// cycle, through all 256 entries; in_ready stays low during the load.
// Stall: when out_ready is low while a result waits, the lookup pipeline and the
// sample generator hold; nothing is dropped.
module fsk_dds_uart_modulator #(
  parameter int SAMPLES_PER_BIT = 20,
  parameter int TABLE_DEPTH     = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          req_type,
  input  wire logic [7:0]                    byte_in,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          result_kind,
  output      logic                          accepted,
  output      logic                          busy_res,
  output      logic [fdu_pkg::SAMPLE_W-1:0]  sample,
  output      logic                          last,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [fdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  logic [31:0]         mark_inc;
  logic [31:0]         space_inc;
  logic                fill_done;
  logic                adv;
  logic                tok_valid;
  fdu_pkg::fdu_token_t tok;
  fdu_pkg::fdu_meta_t  out_meta;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_inc  <= fdu_pkg::MARK_INC_RST;
      space_inc <= fdu_pkg::SPACE_INC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdu_pkg::REG_MARK_INC:  mark_inc  <= cfg_data;
        fdu_pkg::REG_SPACE_INC: space_inc <= cfg_data;
        default: ;
      endcase
    end
  end

  fdu_ctrl #(
    .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .byte_in   (byte_in),
    .mark_inc  (mark_inc),
    .space_inc (space_inc),
    .fill_done (fill_done),
    .adv       (adv),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  fdu_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lookup (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .adv        (adv),
    .fill_done  (fill_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_meta   (out_meta),
    .out_sample (sample)
  );

  assign result_kind = out_meta.kind;
  assign accepted    = out_meta.acc;
  assign busy_res    = out_meta.busy;
  assign last        = out_meta.last;

endmodule

`default_nettype wire

// File: hw/rtl/fdu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fdu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        result_kind,
  input wire logic        accepted,
  input wire logic        busy_res,
  input wire logic [11:0] sample,
  input wire logic        last
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(result_kind))
    else $error("output changed while stalled");

  // Acknowledgements carry no sample and always close their transaction group
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == fdu_pkg::KIND_ACK) |-> (sample == '0) && last)
    else $error("bad acknowledgement");

  // A taken send leaves the transmitter busy
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == fdu_pkg::KIND_ACK) && accepted |-> busy_res)
    else $error("accepted send without busy");

  // Samples never report an accepted send
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == fdu_pkg::KIND_SAMPLE) |-> !accepted)
    else $error("sample flagged accepted");

  // Sine codes stay within the table swing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == fdu_pkg::KIND_SAMPLE) |-> (sample >= 12'd148) && (sample <= 12'd3948))
    else $error("sample out of range");

endmodule

bind fsk_dds_uart_modulator fdu_checker u_fdu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .accepted    (accepted),
  .busy_res    (busy_res),
  .sample      (sample),
  .last        (last)
);

`default_nettype wire

// File: tb/tb_fsk_dds_uart_modulator.sv
`timescale 1ns / 1ps

module tb_fsk_dds_uart_modulator;

  localparam int BIT_SAMPLES = 20;
  localparam int ROM_ENTRIES = 256;
  localparam int FIELD_W     = fdu_pkg::SAMPLE_W;

  // Indexes that map to no register
  localparam logic [fdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [fdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic                         kind;
    logic                         acc;
    logic                         busy;
    logic [fdu_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
  } fsk_result_t;

  // DUT signals
  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          req_type = 1'b0;
  logic [7:0]                    byte_in = 8'd0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          result_kind;
  logic                          accepted;
  logic                          busy_res;
  logic [fdu_pkg::SAMPLE_W-1:0]  sample;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fdu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = 32'd0;

  // Modulator state as predicted by the testbench
  logic [31:0]                  mark_step = fdu_pkg::MARK_INC_RST;
  logic [31:0]                  space_step = fdu_pkg::SPACE_INC_RST;
  logic [31:0]                  dds_phase = 32'd0;
  logic [10:0]                  frame_shift = 11'd0;
  int                           frame_pos = 0;
  logic                         frame_busy = 1'b0;
  logic [fdu_pkg::SAMPLE_W-1:0] sine_rom [ROM_ENTRIES];

  fsk_result_t expected_outputs[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // 1900*sin over a quarter period, both ends included
  int quarter_wave_pts [65] = '{
    0, 46, 93, 139, 186, 232, 278, 324, 370, 416, 461, 506, 551, 595, 640,
    683, 727, 769, 812, 854, 895, 936, 976, 1016, 1055, 1094, 1131, 1168,
    1205, 1241, 1275, 1310, 1343, 1376, 1407, 1438, 1468, 1497, 1526, 1553,
    1579, 1605, 1629, 1653, 1675, 1697, 1717, 1736, 1755, 1772, 1788, 1804,
    1818, 1831, 1843, 1853, 1863, 1872, 1879, 1885, 1890, 1894, 1897, 1899,
    1900
  };

  fsk_dds_uart_modulator #(
    .SAMPLES_PER_BIT(BIT_SAMPLES),
    .TABLE_DEPTH    (ROM_ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .accepted   (accepted),
    .busy_res   (busy_res),
    .sample     (sample),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Expected outputs of one request; updates the predicted state
  task automatic predict_outputs(input fdu_pkg::fdu_req_t req, input logic [7:0] data);
    fsk_result_t r;
    logic        tone_bit;
    logic [31:0] step;
    r = '0;
    if (req == fdu_pkg::REQ_SEND) begin
      r.kind = fdu_pkg::KIND_ACK;
      if (!frame_busy) begin
        // 8O1: start 0, data LSB first, odd parity, stop 1
        frame_shift = {1'b1, ~^data, data, 1'b0};
        frame_pos   = 0;
        frame_busy  = 1'b1;
        r.acc       = 1'b1;
      end
      r.busy = frame_busy;
      r.last = 1'b1;
      expected_outputs.push_back(r);
    end else begin
      // next frame bit, mark when idle
      if (!frame_busy) begin
        tone_bit = 1'b1;
      end else if (frame_pos >= fdu_pkg::FRAME_LEN) begin
        frame_pos  = 0;
        frame_busy = 1'b0;
        tone_bit   = 1'b1;
      end else begin
        tone_bit = frame_shift[frame_pos];
        frame_pos++;
        if (frame_pos >= fdu_pkg::FRAME_LEN) begin
          frame_pos  = 0;
          frame_busy = 1'b0;
        end
      end
      step = tone_bit ? mark_step : space_step;
      for (int n = 0; n < BIT_SAMPLES; n++) begin
        r.kind   = fdu_pkg::KIND_SAMPLE;
        r.acc    = 1'b0;
        r.busy   = frame_busy;
        r.sample = sine_rom[dds_phase[31:24]];
        r.last   = (n == BIT_SAMPLES - 1);
        expected_outputs.push_back(r);
        dds_phase = dds_phase + step;
      end
    end
  endtask

  // One input transaction, with a random gap before it
  task automatic send_item(input fdu_pkg::fdu_req_t req, input logic [7:0] data);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    byte_in  <= data;
    do @(posedge clk); while (!in_ready);
    predict_outputs(req, data);
  endtask

  // Register write transaction
  task automatic write_reg(input logic [fdu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fdu_pkg::REG_MARK_INC:  mark_step = data;
      fdu_pkg::REG_SPACE_INC: space_step = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off input until every expected result is out
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] expd,
                             input logic [FIELD_W-1:0] act);
    if (act !== expd) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expd, act);
      error_count++;
    end
  endtask

  // Result checker and receiver stall generator
  always @(posedge clk) begin : check_results
    fsk_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d sample %0d",
                 $time, result_kind, sample);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        check_field("result_kind", FIELD_W'(want.kind), FIELD_W'(result_kind));
        check_field("accepted", FIELD_W'(want.acc), FIELD_W'(accepted));
        check_field("busy_res", FIELD_W'(want.busy), FIELD_W'(busy_res));
        check_field("sample", want.sample, sample);
        check_field("last", FIELD_W'(want.last), FIELD_W'(last));
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Ticks before any frame: mark tone from phase zero
  task automatic test_idle_ticks();
    send_item(fdu_pkg::REQ_TICK, 8'h00);
    send_item(fdu_pkg::REQ_TICK, 8'hFF);
  endtask

  // Frames of all-zero and all-one bytes, refused send, idle tick after stop
  task automatic test_frame_extremes();
    send_item(fdu_pkg::REQ_SEND, 8'h00);
    send_item(fdu_pkg::REQ_SEND, 8'hFF);
    for (int k = 0; k < fdu_pkg::FRAME_LEN; k++) send_item(fdu_pkg::REQ_TICK, 8'h00);
    send_item(fdu_pkg::REQ_TICK, 8'hFF);
    send_item(fdu_pkg::REQ_SEND, 8'hFF);
    for (int k = 0; k < fdu_pkg::FRAME_LEN; k++) send_item(fdu_pkg::REQ_TICK, 8'hFF);
  endtask

  // Writes to unmapped indexes leave both increments alone
  task automatic test_unmapped_registers();
    wait_for_idle();
    write_reg(REG_UNUSED_2, $urandom());
    write_reg(REG_UNUSED_3, $urandom());
    send_item(fdu_pkg::REQ_TICK, 8'h5A);
  endtask

  // Mostly complete frames with random bytes, plus stray sends and ticks
  task automatic test_random_traffic(input logic [31:0] mark_inc, input logic [31:0] space_inc,
                                     input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int pick;
    wait_for_idle();
    write_reg(fdu_pkg::REG_MARK_INC, mark_inc);
    write_reg(fdu_pkg::REG_SPACE_INC, space_inc);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        send_item(fdu_pkg::REQ_SEND, 8'($urandom_range(255)));
        sent++;
        for (int k = 0; k < fdu_pkg::FRAME_LEN; k++) begin
          if ($urandom_range(9) == 0) begin
            send_item(fdu_pkg::REQ_SEND, 8'($urandom_range(255)));
            sent++;
          end
          send_item(fdu_pkg::REQ_TICK, 8'($urandom_range(255)));
          sent++;
        end
      end else if (pick < 9) begin
        send_item(fdu_pkg::REQ_TICK, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_item(fdu_pkg::REQ_SEND, 8'($urandom_range(255)));
        sent++;
      end
      if ($urandom_range(19) == 0) wait_for_idle();
    end
    // finish a frame still in flight
    while (frame_busy) send_item(fdu_pkg::REQ_TICK, 8'($urandom_range(255)));
  endtask

  // Test sequence
  initial begin : main_seq
    int guard;
    for (int k = 0; k < 64; k++) begin
      sine_rom[k]       = 12'(2048 + quarter_wave_pts[k]);
      sine_rom[64 + k]  = 12'(2048 + quarter_wave_pts[64 - k]);
      sine_rom[128 + k] = 12'(2048 - quarter_wave_pts[k]);
      sine_rom[192 + k] = 12'(2048 - quarter_wave_pts[64 - k]);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_ticks();
    test_frame_extremes();
    test_unmapped_registers();
    test_random_traffic(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 25);
    test_random_traffic(32'hFFFF_FFFF, 32'h0000_0000, 71, 0, 25);
    test_random_traffic($urandom(), $urandom(), 0, 71, 25);
    test_random_traffic(fdu_pkg::MARK_INC_RST, fdu_pkg::SPACE_INC_RST, 30, 30, 25);

    // drain
    in_valid <= 1'b0;
    guard = 0;
    while (expected_outputs.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_outputs.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_outputs.size());
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
